// ----- rtl/fcd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame change detector package
// Register map, reset values and sizing constants shared by the detector.
// ----------------------------------------------------------------------------
package fcd_pkg;

    // Parameter defaults.
    localparam int MAX_WIDTH_DEF  = 4096;
    localparam int COUNT_BITS_DEF = 24;

    // Fixed field widths.
    localparam int CHAN_BITS  = 8;
    localparam int WIDTH_BITS = 13;
    localparam int STEP_BITS  = 5;
    localparam int PHASE_BITS = 4;
    localparam int PCT_BITS   = 7;
    localparam int OUT_CNT_BITS = 24;
    localparam int APB_ADDR_BITS = 5;
    localparam int APB_DATA_BITS = 32;
    localparam int S_DATA_BITS = 48;
    localparam int M_DATA_BITS = 56;

    // Largest sampling stride.
    localparam logic [STEP_BITS-1:0] STEP_MAX = 5'd16;

    // Scale of the percent comparison.
    localparam logic [PCT_BITS-1:0] PCT_SCALE = 7'd100;

    // Register reset values.
    localparam logic [WIDTH_BITS-1:0] FRAME_WIDTH_RST    = 13'd640;
    localparam logic [STEP_BITS-1:0]  SAMPLE_STEP_RST    = 5'd4;
    localparam logic [CHAN_BITS-1:0]  DIFF_THRESHOLD_RST = 8'd24;
    localparam logic [PCT_BITS-1:0]   READY_PERCENT_RST  = 7'd6;
    localparam logic [PCT_BITS-1:0]   CHANGE_PERCENT_RST = 7'd2;

    // Register index, taken from paddr[4:2].
    typedef enum logic [2:0] {
        REG_FRAME_WIDTH    = 3'd0,
        REG_SAMPLE_STEP    = 3'd1,
        REG_DIFF_THRESHOLD = 3'd2,
        REG_READY_PERCENT  = 3'd3,
        REG_CHANGE_PERCENT = 3'd4
    } t_reg_idx;

endpackage

// ----- rtl/frame_change_detector_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame change detector
// Counts sampled and differing pixels of an old/new frame pair and reports
// both counts with two percent flags at the end of each frame.
// ----------------------------------------------------------------------------
// The block takes one pixel pair per clock unless stalled: a pixel is
// registered, then scored and counted as it leaves that register, and the
// result of a frame is offered from the output register after the frame
// totals have passed the flag stage (three COUNT_BITS by 7-bit products and
// two compares). The pipeline only stalls while a finished result is held at
// the output and m_axis_tready is low; s_axis_tready is then low as well.
module frame_change_detector_top #(
    parameter int MAX_WIDTH  = fcd_pkg::MAX_WIDTH_DEF,
    parameter int COUNT_BITS = fcd_pkg::COUNT_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // APB configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [fcd_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [fcd_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic [fcd_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                              pready,
    // Pixel stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // old_blue, old_green, old_red, new_blue, new_green, new_red (8 bits each)
    input  logic [fcd_pkg::S_DATA_BITS-1:0]   s_axis_tdata,
    input  logic                              s_axis_tlast,   // last_pixel
    // Result stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // sampled_count[23:0], differing_count[47:24], view_ready[48],
    // change_detected[49], zero fill[55:50]
    output logic [fcd_pkg::M_DATA_BITS-1:0]   m_axis_tdata
);
    import fcd_pkg::*;

    localparam int PB = $clog2(MAX_WIDTH);
    localparam int CW = (PB + 1 > WIDTH_BITS + 1) ? PB + 1 : WIDTH_BITS + 1;
    localparam int PW = COUNT_BITS + PCT_BITS;
    localparam logic [CW-1:0] MAX_W = CW'(MAX_WIDTH);

    function automatic logic [CHAN_BITS-1:0] abs_diff(input logic [CHAN_BITS-1:0] a,
                                                      input logic [CHAN_BITS-1:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [WIDTH_BITS-1:0] r_frame_width;
    logic [STEP_BITS-1:0]  r_sample_step;
    logic [CHAN_BITS-1:0]  r_diff_threshold;
    logic [PCT_BITS-1:0]   r_ready_percent;
    logic [PCT_BITS-1:0]   r_change_percent;
    t_reg_idx              reg_idx;
    logic                  cfg_wr;

    assign reg_idx = t_reg_idx'(paddr[4:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width    <= FRAME_WIDTH_RST;
            r_sample_step    <= SAMPLE_STEP_RST;
            r_diff_threshold <= DIFF_THRESHOLD_RST;
            r_ready_percent  <= READY_PERCENT_RST;
            r_change_percent <= CHANGE_PERCENT_RST;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_FRAME_WIDTH:    r_frame_width    <= pwdata[WIDTH_BITS-1:0];
                REG_SAMPLE_STEP:    r_sample_step    <= pwdata[STEP_BITS-1:0];
                REG_DIFF_THRESHOLD: r_diff_threshold <= pwdata[CHAN_BITS-1:0];
                REG_READY_PERCENT:  r_ready_percent  <= pwdata[PCT_BITS-1:0];
                REG_CHANGE_PERCENT: r_change_percent <= pwdata[PCT_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_FRAME_WIDTH:    prdata = APB_DATA_BITS'(r_frame_width);
            REG_SAMPLE_STEP:    prdata = APB_DATA_BITS'(r_sample_step);
            REG_DIFF_THRESHOLD: prdata = APB_DATA_BITS'(r_diff_threshold);
            REG_READY_PERCENT:  prdata = APB_DATA_BITS'(r_ready_percent);
            REG_CHANGE_PERCENT: prdata = APB_DATA_BITS'(r_change_percent);
            default:            prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline control: every stage moves unless a result is held.
    // ------------------------------------------------------------------
    logic adv;
    assign adv           = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;

    // Stage 1: input register
    logic                   r_px_valid;
    logic                   r_px_last;
    logic [S_DATA_BITS-1:0] r_px_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_px_valid <= 1'b0;
        end else if (adv) begin
            r_px_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && s_axis_tvalid) begin
            r_px_data <= s_axis_tdata;
            r_px_last <= s_axis_tlast;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: scoring, position tracking and counting
    // ------------------------------------------------------------------
    logic [PB-1:0]         r_col_pos;
    logic [PHASE_BITS-1:0] r_col_phase;
    logic [PHASE_BITS-1:0] r_row_phase;
    logic [COUNT_BITS-1:0] r_smp_tot;
    logic [COUNT_BITS-1:0] r_diff_tot;

    logic [PB-1:0]         n_col_pos;
    logic [PHASE_BITS-1:0] n_col_phase;
    logic [PHASE_BITS-1:0] n_row_phase;
    logic [COUNT_BITS-1:0] n_smp_tot;
    logic [COUNT_BITS-1:0] n_diff_tot;

    logic [CW-1:0]         eff_width;
    logic [STEP_BITS-1:0]  eff_step;
    logic [CW-1:0]         pos_inc;
    logic [STEP_BITS-1:0]  col_inc;
    logic [STEP_BITS-1:0]  row_inc;
    logic                  sampled;
    logic                  differs;
    logic                  step_px;

    always_comb begin
        if (r_frame_width == '0) begin
            eff_width = CW'(1);
        end else if (CW'(r_frame_width) > MAX_W) begin
            eff_width = MAX_W;
        end else begin
            eff_width = CW'(r_frame_width);
        end

        if (r_sample_step == '0) begin
            eff_step = STEP_BITS'(1);
        end else if (r_sample_step > STEP_MAX) begin
            eff_step = STEP_MAX;
        end else begin
            eff_step = r_sample_step;
        end
    end

    assign step_px = adv && r_px_valid;
    assign sampled = (r_col_phase == '0) && (r_row_phase == '0);
    assign differs =
        (abs_diff(r_px_data[7:0],   r_px_data[31:24]) > r_diff_threshold) ||
        (abs_diff(r_px_data[15:8],  r_px_data[39:32]) > r_diff_threshold) ||
        (abs_diff(r_px_data[23:16], r_px_data[47:40]) > r_diff_threshold);

    assign pos_inc = CW'(r_col_pos) + CW'(1);
    assign col_inc = STEP_BITS'(r_col_phase) + STEP_BITS'(1);
    assign row_inc = STEP_BITS'(r_row_phase) + STEP_BITS'(1);

    always_comb begin
        n_smp_tot  = r_smp_tot;
        n_diff_tot = r_diff_tot;
        if (sampled) begin
            if (r_smp_tot != '1) begin
                n_smp_tot = r_smp_tot + COUNT_BITS'(1);
            end
            if (differs && (r_diff_tot != '1)) begin
                n_diff_tot = r_diff_tot + COUNT_BITS'(1);
            end
        end

        // A phase at or past a lowered bound wraps on its next advance.
        if (pos_inc >= eff_width) begin
            n_col_pos   = '0;
            n_col_phase = '0;
            n_row_phase = (row_inc >= eff_step) ? '0 : row_inc[PHASE_BITS-1:0];
        end else begin
            n_col_pos   = pos_inc[PB-1:0];
            n_col_phase = (col_inc >= eff_step) ? '0 : col_inc[PHASE_BITS-1:0];
            n_row_phase = r_row_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_pos   <= '0;
            r_col_phase <= '0;
            r_row_phase <= '0;
            r_smp_tot   <= '0;
            r_diff_tot  <= '0;
        end else if (step_px) begin
            if (r_px_last) begin
                r_col_pos   <= '0;
                r_col_phase <= '0;
                r_row_phase <= '0;
                r_smp_tot   <= '0;
                r_diff_tot  <= '0;
            end else begin
                r_col_pos   <= n_col_pos;
                r_col_phase <= n_col_phase;
                r_row_phase <= n_row_phase;
                r_smp_tot   <= n_smp_tot;
                r_diff_tot  <= n_diff_tot;
            end
        end
    end

    // Frame totals, captured on the last pixel.
    logic                  r_fin_valid;
    logic [COUNT_BITS-1:0] r_fin_smp;
    logic [COUNT_BITS-1:0] r_fin_diff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_valid <= 1'b0;
        end else if (adv) begin
            r_fin_valid <= r_px_valid && r_px_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_px && r_px_last) begin
            r_fin_smp  <= n_smp_tot;
            r_fin_diff <= n_diff_tot;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: percent flags by cross-multiplication, output register
    // ------------------------------------------------------------------
    logic [PW-1:0] diff_scaled;
    logic [PW-1:0] ready_lim;
    logic [PW-1:0] change_lim;
    logic          n_view_ready;
    logic          n_change_det;

    assign diff_scaled = PW'(r_fin_diff) * PW'(PCT_SCALE);
    assign ready_lim   = PW'(r_ready_percent) * PW'(r_fin_smp);
    assign change_lim  = PW'(r_change_percent) * PW'(r_fin_smp);

    // An empty frame always reports a change.
    assign n_view_ready = (r_fin_smp == '0) || (diff_scaled >= ready_lim);
    assign n_change_det = (r_fin_smp == '0) || (diff_scaled >= change_lim);

    logic                  r_out_valid;
    logic [COUNT_BITS-1:0] r_out_smp;
    logic [COUNT_BITS-1:0] r_out_diff;
    logic                  r_out_ready;
    logic                  r_out_change;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_fin_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_fin_valid) begin
            r_out_smp    <= r_fin_smp;
            r_out_diff   <= r_fin_diff;
            r_out_ready  <= n_view_ready;
            r_out_change <= n_change_det;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'b0, r_out_change, r_out_ready,
                            OUT_CNT_BITS'(r_out_diff), OUT_CNT_BITS'(r_out_smp)};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_diff_le_smp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_diff_tot <= r_smp_tot)
        else $error("differing total exceeds sampled total");

    a_empty_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_smp == '0)) |-> (r_out_ready && r_out_change))
        else $error("empty frame did not report both flags");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step_px && r_px_last) |=> ((r_smp_tot == '0) && (r_col_pos == '0)))
        else $error("frame state not cleared after last pixel");

    a_out_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_fin_valid))
        else $error("result appeared without captured totals");

endmodule
